[sv/ppp_afr_pkg.sv]
// ----------------------------------------------------------------------------
// PPP async frame receive package
// Shared types, byte codes and the byte-wide FCS-16 update for the receive
// path.
// ----------------------------------------------------------------------------
package ppp_afr_pkg;

   // Byte codes on the line and inside the frame header
   localparam logic [7:0] FLAG_BYTE = 8'h7E;
   localparam logic [7:0] ESC_BYTE  = 8'h7D;
   localparam logic [7:0] ESC_XOR   = 8'h20;
   localparam logic [7:0] ADDR_BYTE = 8'hFF;
   localparam logic [7:0] CTRL_BYTE = 8'h03;
   localparam logic [7:0] CTRL_CHAR_LIMIT = 8'h20;

   // FCS-16, reflected
   localparam logic [15:0] CHECK_INIT = 16'hFFFF;
   localparam logic [15:0] CHECK_GOOD = 16'hF0B8;
   localparam logic [15:0] CHECK_POLY = 16'h8408;

   // Configuration defaults
   localparam logic [31:0] RX_CHAR_MAP_RESET = 32'h0000_0000;
   localparam logic [11:0] FRAME_LIMIT_RESET = 12'd1504;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 32;

   typedef logic [7:0]  line_type;
   typedef logic [11:0] count_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_RX_CHAR_MAP = 1'b0,
      CSR_FRAME_LIMIT = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      PH_FLAG = 2'd0,
      PH_ADDR = 2'd1,
      PH_CTRL = 2'd2,
      PH_DATA = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      ST_PAYLOAD = 2'd0,
      ST_GOOD    = 2'd1,
      ST_BAD     = 2'd2,
      ST_ABORT   = 2'd3
   } status_type;

   typedef struct packed {
      logic [31:0] rx_char_map;
      count_type   frame_limit;
   } cfg_type;

   typedef struct packed {
      line_type    payload_byte;
      logic        frame_end;
      logic [1:0]  frame_status;
      count_type   frame_length;
   } rsp_type;

   // Fold one byte into the running check, LSB first
   function automatic logic [15:0] check_update(input logic [15:0] crc,
                                                input line_type   data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int b = 0; b < 8; b++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CHECK_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

[sv/ppp_afr_channels.sv]
// ----------------------------------------------------------------------------
// PPP async frame receive channels
// Valid/ready channel bundles for line bytes, results and register writes.
// ----------------------------------------------------------------------------
interface ppp_afr_req_if;
   logic                  valid;
   logic                  ready;
   ppp_afr_pkg::line_type line_byte;

   modport source (output valid, output line_byte, input ready);
   modport sink   (input valid, input line_byte, output ready);
endinterface

interface ppp_afr_rsp_if;
   logic                   valid;
   logic                   ready;
   ppp_afr_pkg::line_type  payload_byte;
   logic                   frame_end;
   logic [1:0]             frame_status;
   ppp_afr_pkg::count_type frame_length;

   modport source (output valid, output payload_byte, output frame_end,
                   output frame_status, output frame_length, input ready);
   modport sink   (input valid, input payload_byte, input frame_end,
                   input frame_status, input frame_length, output ready);
endinterface

interface ppp_afr_csr_if;
   logic                                valid;
   logic                                ready;
   logic [ppp_afr_pkg::CSR_INDEX_W-1:0] index;
   logic [ppp_afr_pkg::CSR_DATA_W-1:0]  wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

[sv/ppp_afr_skid.sv]
// ----------------------------------------------------------------------------
// PPP async frame receive skid register
// Two-entry register stage with a registered upstream ready.
// ----------------------------------------------------------------------------
module ppp_afr_skid #(
   parameter type DATA_TYPE = logic [7:0]
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     up_valid,
   output logic     up_ready,
   input  DATA_TYPE up_data,
   output logic     dn_valid,
   input  logic     dn_ready,
   output DATA_TYPE dn_data
);

   logic     main_valid_ff;
   logic     main_valid_in;
   DATA_TYPE main_data_ff;
   DATA_TYPE main_data_in;
   logic     spare_valid_ff;
   logic     spare_valid_in;
   DATA_TYPE spare_data_ff;
   DATA_TYPE spare_data_in;
   logic     up_fire;
   logic     main_free;

   assign up_ready  = !spare_valid_ff;
   assign up_fire   = up_valid && up_ready;
   assign main_free = !main_valid_ff || dn_ready;
   assign dn_valid  = main_valid_ff;
   assign dn_data   = main_data_ff;

   always_comb begin
      main_valid_in  = main_valid_ff;
      main_data_in   = main_data_ff;
      spare_valid_in = spare_valid_ff;
      spare_data_in  = spare_data_ff;
      if (main_free) begin
         // refill from the spare first, then from upstream
         if (spare_valid_ff) begin
            main_valid_in  = 1'b1;
            main_data_in   = spare_data_ff;
            spare_valid_in = 1'b0;
         end else begin
            main_valid_in = up_fire;
            main_data_in  = up_data;
         end
      end else if (up_fire) begin
         spare_valid_in = 1'b1;
         spare_data_in  = up_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff  <= 1'b0;
         spare_valid_ff <= 1'b0;
      end else begin
         main_valid_ff  <= main_valid_in;
         spare_valid_ff <= spare_valid_in;
      end
      main_data_ff  <= main_data_in;
      spare_data_ff <= spare_data_in;
   end

endmodule

[sv/ppp_afr_core.sv]
// ----------------------------------------------------------------------------
// PPP async frame receive core
// Flag hunt, unescape, control-character drop, header check, FCS-16 and
// length limit for one line byte per cycle while the output takes results.
// ----------------------------------------------------------------------------
module ppp_afr_core (
   input  logic                  clock,
   input  logic                  reset,
   input  ppp_afr_pkg::cfg_type  cfg,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  ppp_afr_pkg::line_type in_byte,
   output logic                  out_valid,
   input  logic                  out_ready,
   output ppp_afr_pkg::rsp_type  out_rsp
);

   ppp_afr_pkg::phase_type phase_ff;
   ppp_afr_pkg::phase_type phase_in;
   logic                   escape_ff;
   logic                   escape_in;
   logic [15:0]            check_ff;
   logic [15:0]            check_in;
   ppp_afr_pkg::count_type count_ff;
   ppp_afr_pkg::count_type count_in;

   logic                   fire;
   logic                   is_flag;
   logic                   is_esc;
   logic                   dropped;
   logic                   store;
   ppp_afr_pkg::line_type  plain;
   logic [15:0]            check_next;

   // Each byte yields at most one result, so a free output slot is enough
   assign in_ready = out_ready;
   assign fire     = in_valid && out_ready;

   assign is_flag = (in_byte == ppp_afr_pkg::FLAG_BYTE);
   assign is_esc  = (in_byte == ppp_afr_pkg::ESC_BYTE);
   assign dropped = (in_byte < ppp_afr_pkg::CTRL_CHAR_LIMIT) && cfg.rx_char_map[in_byte[4:0]];
   assign plain   = escape_ff ? (in_byte ^ ppp_afr_pkg::ESC_XOR) : in_byte;
   assign check_next = ppp_afr_pkg::check_update(check_ff, plain);

   always_comb begin
      phase_in  = phase_ff;
      escape_in = escape_ff;
      check_in  = check_ff;
      count_in  = count_ff;
      store     = 1'b0;
      out_valid = 1'b0;
      out_rsp   = '{payload_byte: '0, frame_end: 1'b0,
                    frame_status: ppp_afr_pkg::ST_PAYLOAD, frame_length: count_ff};
      if (is_flag) begin
         case (phase_ff)
            ppp_afr_pkg::PH_FLAG: begin
               phase_in = ppp_afr_pkg::PH_ADDR;
            end
            ppp_afr_pkg::PH_ADDR: begin
               phase_in = ppp_afr_pkg::PH_ADDR;
            end
            ppp_afr_pkg::PH_CTRL: begin
               phase_in = ppp_afr_pkg::PH_ADDR;
               check_in = ppp_afr_pkg::CHECK_INIT;
               count_in = '0;
            end
            default: begin
               out_valid            = fire;
               out_rsp.frame_end    = 1'b1;
               out_rsp.frame_status = (check_ff == ppp_afr_pkg::CHECK_GOOD) ?
                                      ppp_afr_pkg::ST_GOOD : ppp_afr_pkg::ST_BAD;
               phase_in = ppp_afr_pkg::PH_ADDR;
               check_in = ppp_afr_pkg::CHECK_INIT;
               count_in = '0;
            end
         endcase
      end else if (is_esc) begin
         escape_in = 1'b1;
      end else if (!dropped) begin
         escape_in = 1'b0;
         check_in  = check_next;
         case (phase_ff)
            ppp_afr_pkg::PH_FLAG: begin
               check_in = ppp_afr_pkg::CHECK_INIT;
            end
            ppp_afr_pkg::PH_CTRL: begin
               if (plain == ppp_afr_pkg::CTRL_BYTE) begin
                  phase_in = ppp_afr_pkg::PH_DATA;
               end else begin
                  phase_in = ppp_afr_pkg::PH_FLAG;
                  check_in = ppp_afr_pkg::CHECK_INIT;
                  count_in = '0;
               end
            end
            ppp_afr_pkg::PH_ADDR: begin
               // anything but the address byte is a compressed header
               if (plain == ppp_afr_pkg::ADDR_BYTE) begin
                  phase_in = ppp_afr_pkg::PH_CTRL;
               end else begin
                  phase_in = ppp_afr_pkg::PH_DATA;
                  store    = 1'b1;
               end
            end
            default: begin
               store = 1'b1;
            end
         endcase
         if (store) begin
            out_valid = fire;
            if (count_ff < cfg.frame_limit) begin
               count_in             = count_ff + 12'd1;
               out_rsp.payload_byte = plain;
               out_rsp.frame_length = count_ff + 12'd1;
            end else begin
               out_rsp.frame_end    = 1'b1;
               out_rsp.frame_status = ppp_afr_pkg::ST_ABORT;
               phase_in = ppp_afr_pkg::PH_FLAG;
               check_in = ppp_afr_pkg::CHECK_INIT;
               count_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= ppp_afr_pkg::PH_FLAG;
         escape_ff <= 1'b0;
         check_ff  <= ppp_afr_pkg::CHECK_INIT;
         count_ff  <= '0;
      end else if (fire) begin
         phase_ff  <= phase_in;
         escape_ff <= escape_in;
         check_ff  <= check_in;
         count_ff  <= count_in;
      end
   end

endmodule

[sv/ppp_async_frame_receive_unit.sv]
// ----------------------------------------------------------------------------
// PPP async frame receive unit
// Deframes an async HDLC-like PPP byte stream and checks its FCS-16.
// ----------------------------------------------------------------------------
// Accepts one raw line byte per request on req_ch and sustains one byte per
// clock while rsp_ch takes results. A byte passes an input skid register,
// the combinational deframing logic (flag hunt, unescape, control-character
// drop, header check, byte-wide FCS-16 update) and an output skid register,
// from which its result is presented on rsp_ch; the byte-wide FCS update and
// the frame state register set that one-byte-per-clock rate. Bytes that make
// no result (flags, escapes, dropped characters, header bytes) still pass
// through the core, which holds whenever the output register is full; they
// add no bubble of their own. Each stored payload byte, FCS bytes included,
// is delivered with its running length; a closing flag delivers a frame end
// with good or bad FCS status, and a byte past frame_limit delivers an abort
// status. Registers on csr_ch: index 0 is the receive character map, index 1
// the frame limit; write them only while idle.
// ----------------------------------------------------------------------------
module ppp_async_frame_receive_unit (
   input logic          clock,
   input logic          reset,
   ppp_afr_req_if.sink  req_ch,
   ppp_afr_rsp_if.source rsp_ch,
   ppp_afr_csr_if.sink  csr_ch
);

   ppp_afr_pkg::cfg_type  cfg_ff;
   ppp_afr_pkg::cfg_type  cfg_in;

   logic                  core_in_valid;
   logic                  core_in_ready;
   ppp_afr_pkg::line_type core_in_byte;
   logic                  core_out_valid;
   logic                  core_out_ready;
   ppp_afr_pkg::rsp_type  core_out_rsp;
   ppp_afr_pkg::rsp_type  rsp_data;

   // Register writes never stall
   assign csr_ch.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         case (ppp_afr_pkg::csr_index_type'(csr_ch.index))
            ppp_afr_pkg::CSR_RX_CHAR_MAP: cfg_in.rx_char_map = csr_ch.wdata;
            ppp_afr_pkg::CSR_FRAME_LIMIT: cfg_in.frame_limit = csr_ch.wdata[11:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{rx_char_map: ppp_afr_pkg::RX_CHAR_MAP_RESET,
                     frame_limit: ppp_afr_pkg::FRAME_LIMIT_RESET};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Hold incoming line bytes; ready toward the line is registered
   ppp_afr_skid #(
      .DATA_TYPE (ppp_afr_pkg::line_type)
   ) u_in_stage (
      .clock    (clock),
      .reset    (reset),
      .up_valid (req_ch.valid),
      .up_ready (req_ch.ready),
      .up_data  (req_ch.line_byte),
      .dn_valid (core_in_valid),
      .dn_ready (core_in_ready),
      .dn_data  (core_in_byte)
   );

   // Advance the frame state by one byte per cycle while the output has room
   ppp_afr_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (core_in_valid),
      .in_ready  (core_in_ready),
      .in_byte   (core_in_byte),
      .out_valid (core_out_valid),
      .out_ready (core_out_ready),
      .out_rsp   (core_out_rsp)
   );

   // Hold results until the consumer takes them
   ppp_afr_skid #(
      .DATA_TYPE (ppp_afr_pkg::rsp_type)
   ) u_out_stage (
      .clock    (clock),
      .reset    (reset),
      .up_valid (core_out_valid),
      .up_ready (core_out_ready),
      .up_data  (core_out_rsp),
      .dn_valid (rsp_ch.valid),
      .dn_ready (rsp_ch.ready),
      .dn_data  (rsp_data)
   );

   assign rsp_ch.payload_byte = rsp_data.payload_byte;
   assign rsp_ch.frame_end    = rsp_data.frame_end;
   assign rsp_ch.frame_status = rsp_data.frame_status;
   assign rsp_ch.frame_length = rsp_data.frame_length;

endmodule
